// File: rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// Bounded composition counter package
// Shared widths, codes and the control and status structs of the fill unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

  localparam int LEN_W       = 12;
  localparam int TABLE_DEPTH = 2 ** LEN_W;
  localparam int CNT_W       = 63;
  localparam int WIN_W       = CNT_W + 1;
  localparam int PART_W      = 17;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [PART_W-1:0] PART_LIMIT = PART_W'(65536);

  // Register word index, taken from paddr[2].
  localparam logic REG_MIN_PART = 1'b0;
  localparam logic REG_MAX_PART = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_BAD_RANGE = 2'd2
  } bcc_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_DONE
  } bcc_state_t;

  typedef struct packed {
    logic init;
    logic step;
  } fill_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] ways;
    logic             ovf;
    logic [LEN_W-1:0] idx;
  } fill_stat_t;

endpackage

`default_nettype wire

// File: rtl/bcc_fill.sv
// ----------------------------------------------------------------------------
// Bounded composition table fill unit
// Holds the ways table and the window sum, and produces one table entry per
// step with a single add/subtract unit and a dual-read table memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bcc_fill
  import bcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fill_ctrl_t        ctrl,
  input  wire logic [PART_W-1:0] min_part,
  input  wire logic [PART_W-1:0] max_part,
  output fill_stat_t             stat
);

  logic [CNT_W-1:0] mem [0:TABLE_DEPTH-1];

  logic [LEN_W-1:0] idx;
  logic [WIN_W-1:0] win;
  logic [CNT_W-1:0] rd_ent;
  logic [CNT_W-1:0] rd_lve;
  logic [CNT_W-1:0] fwd_val;
  logic             ent_use;
  logic             ent_fwd;
  logic             lve_use;

  logic [LEN_W-1:0] k;
  logic [LEN_W:0]   kp1;
  logic [LEN_W-1:0] ent_addr;
  logic [LEN_W-1:0] lve_addr;
  logic             ent_use_next;
  logic             lve_use_next;
  logic [CNT_W-1:0] ent_term;
  logic [CNT_W-1:0] lve_term;
  logic [WIN_W-1:0] diff;
  logic             ovf;
  logic             issue;
  logic             we;
  logic [CNT_W-1:0] wdata;

  always_comb begin
    k            = ctrl.init ? '0 : idx;
    kp1          = {1'b0, k} + (LEN_W + 1)'(1);
    ent_use_next = {{(PART_W-LEN_W-1){1'b0}}, kp1} >= min_part;
    lve_use_next = {{(PART_W-LEN_W){1'b0}}, k} >= max_part;
    ent_addr     = LEN_W'(kp1 - min_part[LEN_W:0]);
    lve_addr     = k - max_part[LEN_W-1:0];

    ent_term = ent_use ? (ent_fwd ? fwd_val : rd_ent) : '0;
    lve_term = lve_use ? rd_lve : '0;
    diff     = win + {1'b0, ent_term} - {1'b0, lve_term};
    ovf      = diff[WIN_W-1];

    issue = ctrl.init || (ctrl.step && !ovf);
    we    = issue;
    wdata = ctrl.init ? CNT_W'(1) : diff[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      win     <= '0;
      ent_use <= 1'b0;
      ent_fwd <= 1'b0;
      lve_use <= 1'b0;
    end else if (ctrl.init) begin
      idx     <= LEN_W'(1);
      win     <= '0;
      ent_use <= ent_use_next;
      ent_fwd <= min_part == PART_W'(1);
      lve_use <= lve_use_next;
    end else if (ctrl.step && !ovf) begin
      idx     <= idx + LEN_W'(1);
      win     <= diff;
      ent_use <= ent_use_next;
      lve_use <= lve_use_next;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      fwd_val <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[k] <= wdata;
    end
    rd_ent <= mem[ent_addr];
    rd_lve <= mem[lve_addr];
  end

  assign stat.ways = diff[CNT_W-1:0];
  assign stat.ovf  = ovf;
  assign stat.idx  = idx;

endmodule

`default_nettype wire

// File: rtl/bounded_composition_counter.sv
// ----------------------------------------------------------------------------
// Bounded composition counter
// Counts ordered compositions of a target length into parts whose sizes lie
// between the configured minimum and maximum part size.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                    Direction
//   config    psel penable pwrite paddr pwdata prdata    APB slave
//   input     in_valid in_stall target_length            sink
//   output    out_valid out_stall way_count status       source
//
// A transaction with target_length n > 0 and a good range fills the table
// one entry per cycle with the single window adder and the table memory.
// A bad range or a zero target skips the fill and goes straight to the
// done state. Input is stalled while a transaction is in progress. A
// result waits in the output register while out_stall is high, and the
// next input transaction is taken meanwhile.
// Reset sets both part sizes to 1 and clears the window sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_composition_counter
  import bcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [LEN_W-1:0]  target_length,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [CNT_W-1:0]  way_count,
  output logic      [1:0]        status
);

  bcc_state_t        state;
  bcc_state_t        state_next;
  logic [PART_W-1:0] min_part;
  logic [PART_W-1:0] max_part;
  logic [LEN_W-1:0]  target;
  logic [CNT_W-1:0]  res_count;
  logic [CNT_W-1:0]  res_count_next;
  bcc_status_t       res_status;
  bcc_status_t       res_status_next;
  logic              res_load;
  logic              out_load;
  logic              bad_range;
  fill_ctrl_t        ctrl;
  fill_stat_t        stat;

  bcc_fill u_fill (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .min_part (min_part),
    .max_part (max_part),
    .stat     (stat)
  );

  assign pready = 1'b1;
  assign prdata = {{(DATA_W-PART_W){1'b0}}, (paddr[2] == REG_MAX_PART) ? max_part : min_part};

  always_ff @(posedge clk) begin
    if (rst) begin
      min_part <= PART_W'(1);
      max_part <= PART_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_MIN_PART: min_part <= pwdata[PART_W-1:0];
        REG_MAX_PART: max_part <= pwdata[PART_W-1:0];
        default: ;
      endcase
    end
  end

  assign bad_range = (min_part == '0) || (max_part < min_part) || (max_part > PART_LIMIT);

  always_comb begin
    state_next      = state;
    ctrl            = '0;
    res_load        = 1'b0;
    res_count_next  = '0;
    res_status_next = STATUS_OK;
    out_load        = 1'b0;
    in_stall        = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (bad_range) begin
            res_load        = 1'b1;
            res_status_next = STATUS_BAD_RANGE;
            state_next      = ST_DONE;
          end else if (target_length == '0) begin
            res_load       = 1'b1;
            res_count_next = CNT_W'(1);
            state_next     = ST_DONE;
          end else begin
            ctrl.init  = 1'b1;
            state_next = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        ctrl.step = 1'b1;
        if (stat.ovf) begin
          res_load        = 1'b1;
          res_status_next = STATUS_OVERFLOW;
          state_next      = ST_DONE;
        end else if (stat.idx == target) begin
          res_load       = 1'b1;
          res_count_next = stat.ways;
          state_next     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      target <= target_length;
    end
    if (res_load) begin
      res_count  <= res_count_next;
      res_status <= res_status_next;
    end
    if (out_load) begin
      way_count <= res_count;
      status    <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_nonzero_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> way_count == '0)
    else $error("nonzero count with an error status");

  a_bad_range_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && in_valid && bad_range |=> state == ST_DONE && res_status == STATUS_BAD_RANGE)
    else $error("bad range not reported at once");

  a_idx_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_FILL |-> stat.idx <= target && stat.idx != '0)
    else $error("fill index outside the target range");

  a_fill_starts: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_FILL) |-> stat.idx == LEN_W'(1))
    else $error("fill did not start at entry one");

endmodule

`default_nettype wire
